FILE: src/rles_pkg.sv
// Shared codes, types and lookup functions for the RGB LED effect sequencer.
`timescale 1ns / 1ps
`default_nettype none
package rles_pkg;

    // Field widths
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned SET_W    = 3;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned MS_W     = 10;
    localparam int unsigned DELAY_W  = 7;
    localparam int unsigned LINES_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_TICK       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_COLOUR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_MODE   = 2'd2;

    // Modes
    localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ON      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ALARM   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FLICKER = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DISCO   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FAILURE = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCO_PERIOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_PERIOD = 2'd2;

    // Reset values and limits
    localparam logic [MS_W-1:0] ALARM_PERIOD_RST   = 10'd250;
    localparam logic [MS_W-1:0] DISCO_PERIOD_RST   = 10'd500;
    localparam logic [MS_W-1:0] FAILURE_PERIOD_RST = 10'd250;
    localparam logic [MS_W-1:0] ELAPSED_MAX        = 10'd1023;

    // Line patterns: red bit 2, green bit 1, blue bit 0
    localparam logic [LINES_W-1:0] LINES_DARK  = 3'b000;
    localparam logic [LINES_W-1:0] LINES_WHITE = 3'b111;

    localparam logic [PHASE_W-1:0] PHASE_LIT      = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_FIRST    = 3'd0;
    localparam logic [PHASE_W-1:0] FAILURE_LAST   = 3'd5;
    localparam logic [PHASE_W-1:0] FAILURE_END    = 3'd6;
    localparam logic [PHASE_W:0]   FLICKER_STEPS  = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_MIN      = 4'd1;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX      = 4'd9;

    // Sequencer state
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SET_W-1:0]   colour;
        logic [PHASE_W-1:0] phase;
        logic [MS_W-1:0]    elapsed;
        logic [DELAY_W-1:0] delay;
        logic [LINES_W-1:0] lines;
    } t_state;

    // Blink and step periods
    typedef struct packed {
        logic [MS_W-1:0] alarm;
        logic [MS_W-1:0] disco;
        logic [MS_W-1:0] failure;
    } t_periods;

    // One result item
    typedef struct packed {
        logic [LINES_W-1:0] lines;
        logic [MODE_W-1:0]  mode;
    } t_result;

    // Colour code to line pattern
    function automatic logic [LINES_W-1:0] colour_lines(input logic [SET_W-1:0] c);
        logic [LINES_W-1:0] l;
        case (c)
            3'd0:    l = 3'b000;
            3'd1:    l = 3'b111;
            3'd2:    l = 3'b100;
            3'd3:    l = 3'b010;
            3'd4:    l = 3'b001;
            3'd5:    l = 3'b101;
            3'd6:    l = 3'b110;
            default: l = 3'b011;
        endcase
        return l;
    endfunction

    // Failure sequence: red, green, blue, magenta, yellow, cyan
    function automatic logic [LINES_W-1:0] failure_lines(input logic [PHASE_W-1:0] p);
        logic [LINES_W-1:0] l;
        case (p)
            3'd0:    l = 3'b100;
            3'd1:    l = 3'b010;
            3'd2:    l = 3'b001;
            3'd3:    l = 3'b101;
            3'd4:    l = 3'b110;
            default: l = 3'b011;
        endcase
        return l;
    endfunction

    // Flicker sequence: cyan, white, blue
    function automatic logic [LINES_W-1:0] flicker_lines(input logic [PHASE_W-1:0] p);
        logic [LINES_W-1:0] l;
        case (p)
            3'd0:    l = 3'b011;
            3'd1:    l = 3'b111;
            default: l = 3'b001;
        endcase
        return l;
    endfunction

endpackage
`default_nettype wire

FILE: src/rgb_led_effect_sequencer_unit.sv
// Top level of the RGB LED effect sequencer: state, config registers, result buffer.
// A result item enters the output register, or the skid stage while that is full, when its input item is accepted.
// Throughput: one item per cycle while the result buffer is not full; the state update is a single registered pass.
// A two-entry result buffer keeps input flowing while one result waits.
// Reset (synchronous, active low): mode off, colour black, lines dark, counters
// and phase zero, periods 250/500/250 ms, result buffer empty.
`timescale 1ns / 1ps
`default_nettype none
module rgb_led_effect_sequencer_unit (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    // configuration
    input  wire                                    i_cfg_we,
    input  wire logic [rles_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [rles_pkg::MS_W-1:0]         i_cfg_data,
    // input items
    input  wire                                    i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [rles_pkg::CMD_W-1:0]        i_command,
    input  wire logic [rles_pkg::SET_W-1:0]        i_setting,
    input  wire logic [rles_pkg::DIGIT_W-1:0]      i_rand_digit,
    // result items
    output logic                                   o_out_valid,
    input  wire                                    i_out_stall,
    output logic                                   o_red_on,
    output logic                                   o_green_on,
    output logic                                   o_blue_on,
    output logic [rles_pkg::MODE_W-1:0]            o_active_mode
);

    rles_pkg::t_state   r_state;
    rles_pkg::t_state   n_state;
    rles_pkg::t_periods r_periods;
    rles_pkg::t_result  res;
    rles_pkg::t_result  out_data;
    logic               accept;
    logic               buf_full;

    assign o_in_stall = buf_full;
    assign accept     = i_in_valid & ~buf_full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_periods.alarm   <= rles_pkg::ALARM_PERIOD_RST;
            r_periods.disco   <= rles_pkg::DISCO_PERIOD_RST;
            r_periods.failure <= rles_pkg::FAILURE_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rles_pkg::CFG_ALARM_PERIOD:   r_periods.alarm   <= i_cfg_data;
                rles_pkg::CFG_DISCO_PERIOD:   r_periods.disco   <= i_cfg_data;
                rles_pkg::CFG_FAILURE_PERIOD: r_periods.failure <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Effect step
    rles_core u_core (
        .i_state      (r_state),
        .i_periods    (r_periods),
        .i_command    (i_command),
        .i_setting    (i_setting),
        .i_rand_digit (i_rand_digit),
        .o_state      (n_state)
    );

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    assign res.lines = n_state.lines;
    assign res.mode  = n_state.mode;

    // Result buffer
    rles_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_data)
    );

    assign o_red_on      = out_data.lines[2];
    assign o_green_on    = out_data.lines[1];
    assign o_blue_on     = out_data.lines[0];
    assign o_active_mode = out_data.mode;

endmodule
`default_nettype wire

FILE: src/rles_core.sv
// Next-state logic of the LED sequencer for one item.
`timescale 1ns / 1ps
`default_nettype none
module rles_core (
    input  wire rles_pkg::t_state                    i_state,
    input  wire rles_pkg::t_periods                  i_periods,
    input  wire logic [rles_pkg::CMD_W-1:0]          i_command,
    input  wire logic [rles_pkg::SET_W-1:0]          i_setting,
    input  wire logic [rles_pkg::DIGIT_W-1:0]        i_rand_digit,
    output rles_pkg::t_state                         o_state
);

    logic [rles_pkg::MS_W-1:0]    el;
    logic [rles_pkg::DIGIT_W-1:0] digit;
    logic [rles_pkg::DELAY_W-1:0] digit_x10;
    logic [rles_pkg::PHASE_W:0]   ph_inc;
    logic                         lit_phase;

    // Saturating elapsed count, clamped digit, next phase and lit-phase flag
    always_comb begin
        el = (i_state.elapsed != rles_pkg::ELAPSED_MAX) ?
             i_state.elapsed + 10'd1 : i_state.elapsed;
        if (i_rand_digit < rles_pkg::DIGIT_MIN) begin
            digit = rles_pkg::DIGIT_MIN;
        end else if (i_rand_digit > rles_pkg::DIGIT_MAX) begin
            digit = rles_pkg::DIGIT_MAX;
        end else begin
            digit = i_rand_digit;
        end
        digit_x10 = ({3'b000, digit} << 3) + ({3'b000, digit} << 1);
        ph_inc    = {1'b0, i_state.phase} + 4'd1;
        lit_phase = (i_state.phase == rles_pkg::PHASE_LIT);
    end

    // Command decode and effect step
    always_comb begin
        o_state = i_state;
        unique case (i_command)
            rles_pkg::CMD_TICK: begin
                o_state.elapsed = el;
                case (i_state.mode)
                    rles_pkg::MODE_OFF: begin
                        o_state.lines = rles_pkg::LINES_DARK;
                    end
                    rles_pkg::MODE_ON: begin
                        o_state.lines = rles_pkg::colour_lines(i_state.colour);
                    end
                    rles_pkg::MODE_ALARM: begin
                        if (el >= i_periods.alarm) begin
                            o_state.elapsed = '0;
                            o_state.lines = lit_phase ?
                                rles_pkg::colour_lines(i_state.colour) : rles_pkg::LINES_DARK;
                            o_state.phase = lit_phase ? rles_pkg::PHASE_FIRST : rles_pkg::PHASE_LIT;
                        end
                    end
                    rles_pkg::MODE_DISCO: begin
                        if (el >= i_periods.disco) begin
                            o_state.elapsed = '0;
                            o_state.lines = lit_phase ? rles_pkg::LINES_WHITE : rles_pkg::LINES_DARK;
                            o_state.phase = lit_phase ? rles_pkg::PHASE_FIRST : rles_pkg::PHASE_LIT;
                        end
                    end
                    rles_pkg::MODE_FAILURE: begin
                        if (el >= i_periods.failure) begin
                            o_state.elapsed = '0;
                            if (i_state.phase <= rles_pkg::FAILURE_LAST) begin
                                o_state.lines = rles_pkg::failure_lines(i_state.phase);
                            end else if (i_state.phase == rles_pkg::FAILURE_END) begin
                                // sequence done: back to off, lines hold
                                o_state.mode = rles_pkg::MODE_OFF;
                            end
                            o_state.phase = ph_inc[rles_pkg::PHASE_W-1:0];
                        end
                    end
                    rles_pkg::MODE_FLICKER: begin
                        if (el >= {3'b000, i_state.delay}) begin
                            o_state.elapsed = '0;
                            if ({1'b0, i_state.phase} < rles_pkg::FLICKER_STEPS) begin
                                o_state.lines = rles_pkg::flicker_lines(i_state.phase);
                            end
                            o_state.delay = digit_x10;
                            o_state.phase = (ph_inc >= rles_pkg::FLICKER_STEPS) ?
                                rles_pkg::PHASE_FIRST : ph_inc[rles_pkg::PHASE_W-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            rles_pkg::CMD_SET_COLOUR: begin
                o_state.colour = i_setting;
            end
            rles_pkg::CMD_SET_MODE: begin
                case (i_setting)
                    rles_pkg::MODE_OFF, rles_pkg::MODE_ON: begin
                        o_state.mode = i_setting;
                    end
                    rles_pkg::MODE_ALARM, rles_pkg::MODE_DISCO: begin
                        o_state.mode  = i_setting;
                        o_state.phase = rles_pkg::PHASE_LIT;
                    end
                    rles_pkg::MODE_FAILURE: begin
                        o_state.mode  = i_setting;
                        o_state.phase = rles_pkg::PHASE_FIRST;
                    end
                    rles_pkg::MODE_FLICKER: begin
                        o_state.mode  = i_setting;
                        o_state.phase = rles_pkg::PHASE_FIRST;
                        o_state.delay = '0;
                    end
                    default: begin
                        // unknown mode codes are ignored
                    end
                endcase
            end
            default: begin
                // unknown command: no change
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: src/rles_out_buf.sv
// Two-entry result buffer: output register plus skid stage.
`timescale 1ns / 1ps
`default_nettype none
module rles_out_buf (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  wire rles_pkg::t_result i_data,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire                    i_stall,
    output rles_pkg::t_result      o_data
);

    logic              r_out_valid;
    logic              r_skid_valid;
    rles_pkg::t_result r_out;
    rles_pkg::t_result r_skid;
    logic              take;

    assign take    = r_out_valid & ~i_stall;
    assign o_valid = r_out_valid;
    assign o_full  = r_skid_valid;
    assign o_data  = r_out;

    // Control: skid refills the output register when it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

endmodule
`default_nettype wire

FILE: bench/rles_effect_checker.sv
// Result checker for the RGB LED effect sequencer: tracks state, predicts and compares items.
`timescale 1ns / 1ps
module rles_effect_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire [rles_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [rles_pkg::MS_W-1:0]            i_cfg_data,
    input  wire                                 i_in_valid,
    input  wire                                 i_in_stall,
    input  wire [rles_pkg::CMD_W-1:0]           i_command,
    input  wire [rles_pkg::SET_W-1:0]           i_setting,
    input  wire [rles_pkg::DIGIT_W-1:0]         i_rand_digit,
    input  wire                                 i_out_valid,
    input  wire                                 i_out_stall,
    input  wire                                 i_red_on,
    input  wire                                 i_green_on,
    input  wire                                 i_blue_on,
    input  wire [rles_pkg::MODE_W-1:0]          i_active_mode,
    output int                                  o_mismatches,
    output int                                  o_pending
);
    import rles_pkg::*;

    // Line patterns packed three bits per entry, entry 0 at the bottom
    localparam logic [23:0] COLOUR_MAP  = {3'b011, 3'b110, 3'b101, 3'b001,
                                           3'b010, 3'b100, 3'b111, 3'b000};
    localparam logic [17:0] FAILURE_MAP = {3'b011, 3'b110, 3'b101, 3'b001, 3'b010, 3'b100};
    localparam logic [8:0]  FLICKER_MAP = {3'b001, 3'b111, 3'b011};

    // Predicted sequencer state and periods
    logic [MODE_W-1:0]  run_mode     = MODE_OFF;
    logic [SET_W-1:0]   colour_code  = '0;
    logic [PHASE_W-1:0] step         = '0;
    logic [MS_W-1:0]    elapsed      = '0;
    logic [DELAY_W-1:0] flicker_wait = '0;
    logic [LINES_W-1:0] lines        = LINES_DARK;
    logic [MS_W-1:0]    alarm_ms     = ALARM_PERIOD_RST;
    logic [MS_W-1:0]    disco_ms     = DISCO_PERIOD_RST;
    logic [MS_W-1:0]    failure_ms   = FAILURE_PERIOD_RST;

    t_result led_results_q[$];
    t_result want;
    int      mismatch_count = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // True once the shared counter reaches the period; restarts the count
    function automatic bit period_over(input logic [MS_W-1:0] period);
        if (elapsed < period)
            return 1'b0;
        elapsed = '0;
        return 1'b1;
    endfunction

    task automatic enter_mode(input logic [SET_W-1:0] m);
        case (m)
            MODE_OFF, MODE_ON: begin
                run_mode = m;
            end
            MODE_ALARM, MODE_DISCO: begin
                run_mode = m;
                step     = PHASE_LIT;
            end
            MODE_FAILURE: begin
                run_mode = m;
                step     = PHASE_FIRST;
            end
            MODE_FLICKER: begin
                run_mode     = m;
                step         = PHASE_FIRST;
                flicker_wait = '0;
            end
            default: ;  // undefined modes are ignored
        endcase
    endtask

    // One millisecond of the current effect
    task automatic run_tick(input logic [DIGIT_W-1:0] digit);
        logic [DIGIT_W-1:0] d;
        d = digit;
        if (elapsed < ELAPSED_MAX)
            elapsed = elapsed + 10'd1;
        case (run_mode)
            MODE_OFF: lines = LINES_DARK;
            MODE_ON:  lines = COLOUR_MAP[3*int'(colour_code) +: 3];
            MODE_ALARM: begin
                if (period_over(alarm_ms)) begin
                    lines = (step == PHASE_LIT) ? COLOUR_MAP[3*int'(colour_code) +: 3]
                                                : LINES_DARK;
                    step  = (step == PHASE_LIT) ? PHASE_FIRST : PHASE_LIT;
                end
            end
            MODE_DISCO: begin
                if (period_over(disco_ms)) begin
                    lines = (step == PHASE_LIT) ? LINES_WHITE : LINES_DARK;
                    step  = (step == PHASE_LIT) ? PHASE_FIRST : PHASE_LIT;
                end
            end
            MODE_FAILURE: begin
                if (period_over(failure_ms)) begin
                    if (step <= FAILURE_LAST)
                        lines = FAILURE_MAP[3*int'(step) +: 3];
                    else if (step == FAILURE_END)
                        run_mode = MODE_OFF;  // lines stay until the next tick
                    step = step + 3'd1;
                end
            end
            MODE_FLICKER: begin
                if (period_over(MS_W'(flicker_wait))) begin
                    if ({1'b0, step} < FLICKER_STEPS)
                        lines = FLICKER_MAP[3*int'(step) +: 3];
                    if (d < DIGIT_MIN)
                        d = DIGIT_MIN;
                    if (d > DIGIT_MAX)
                        d = DIGIT_MAX;
                    flicker_wait = DELAY_W'(d) * 7'd10;
                    step = step + 3'd1;
                    if ({1'b0, step} >= FLICKER_STEPS)
                        step = PHASE_FIRST;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string what, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val,
                     act_val);
            mismatch_count++;
        end
    endtask

    // Watch both channels and the register port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_mode       = MODE_OFF;
            colour_code    = '0;
            step           = '0;
            elapsed        = '0;
            flicker_wait   = '0;
            lines          = LINES_DARK;
            alarm_ms       = ALARM_PERIOD_RST;
            disco_ms       = DISCO_PERIOD_RST;
            failure_ms     = FAILURE_PERIOD_RST;
            mismatch_count = 0;
            led_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ALARM_PERIOD:   alarm_ms   = i_cfg_data;
                    CFG_DISCO_PERIOD:   disco_ms   = i_cfg_data;
                    CFG_FAILURE_PERIOD: failure_ms = i_cfg_data;
                    default: ;
                endcase
            end
            // result side first: it always belongs to an earlier item
            if (i_out_valid && !i_out_stall) begin
                if (led_results_q.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, actual lines %b mode %0d",
                             $time, {i_red_on, i_green_on, i_blue_on}, i_active_mode);
                    mismatch_count++;
                end else begin
                    want = led_results_q.pop_front();
                    check_field("red_on", int'(want.lines[2]), int'(i_red_on));
                    check_field("green_on", int'(want.lines[1]), int'(i_green_on));
                    check_field("blue_on", int'(want.lines[0]), int'(i_blue_on));
                    check_field("active_mode", int'(want.mode), int'(i_active_mode));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_command)
                    CMD_TICK:       run_tick(i_rand_digit);
                    CMD_SET_COLOUR: colour_code = i_setting;
                    CMD_SET_MODE:   enter_mode(i_setting);
                    default: ;  // unused command changes nothing
                endcase
                led_results_q.push_back('{lines: lines, mode: run_mode});
            end
        end
        o_pending    <= led_results_q.size();
        o_mismatches <= mismatch_count;
    end

endmodule

FILE: bench/rgb_led_effect_sequencer_unit_tb.sv
// Testbench top for the RGB LED effect sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module rgb_led_effect_sequencer_unit_tb;
    import rles_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_UNUSED     = 2'd3;
    localparam logic [SET_W-1:0]     MODE_UNDEF_LO  = 3'd6;
    localparam logic [SET_W-1:0]     MODE_UNDEF_HI  = 3'd7;
    localparam logic [SET_W-1:0]     COLOUR_BLACK   = 3'd0;
    localparam logic [SET_W-1:0]     COLOUR_YELLOW  = 3'd6;
    localparam logic [SET_W-1:0]     COLOUR_CYAN    = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;
    localparam int                   HOLD_OFF_CYCLES = 64;
    localparam int                   IDLE_LIMIT      = 2000;
    localparam int                   PHASE_ITEMS     = 330;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [MS_W-1:0]      cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [CMD_W-1:0]     command     = '0;
    logic [SET_W-1:0]     setting     = '0;
    logic [DIGIT_W-1:0]   rand_digit  = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic                 red_on;
    logic                 green_on;
    logic                 blue_on;
    logic [MODE_W-1:0]    active_mode;

    int mismatches;
    int pending;
    int burst_left    = 0;
    int idle_cycles   = 0;
    bit hold_off_req  = 1'b0;

    rgb_led_effect_sequencer_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_command     (command),
        .i_setting     (setting),
        .i_rand_digit  (rand_digit),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_red_on      (red_on),
        .o_green_on    (green_on),
        .o_blue_on     (blue_on),
        .o_active_mode (active_mode)
    );

    rles_effect_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_command     (command),
        .i_setting     (setting),
        .i_rand_digit  (rand_digit),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_red_on      (red_on),
        .i_green_on    (green_on),
        .i_blue_on     (blue_on),
        .i_active_mode (active_mode),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // 100 MHz clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: cycles with no item moving on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: stall density changes per stretch, long hold-off on request
    initial begin : receiver
        int stall_pct;
        int stretch;
        forever begin
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                2:       stall_pct = 50;
                default: stall_pct = 85;
            endcase
            stretch = $urandom_range(10, 200);
            repeat (stretch) begin
                @(posedge clk);
                if (hold_off_req) begin
                    out_stall <= 1'b1;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                    hold_off_req = 1'b0;
                end
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Offer one item and wait until it is taken; bursts end in a short gap
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SET_W-1:0] set_val,
                             input logic [DIGIT_W-1:0] digit);
        bit stalled;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        setting    <= set_val;
        rand_digit <= digit;
        // stall is sampled mid-cycle, where it is stable for the coming edge
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
        burst_left--;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic settle();
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_periods(input logic [MS_W-1:0] alarm, input logic [MS_W-1:0] disco,
                               input logic [MS_W-1:0] failure);
        settle();
        write_reg(CFG_ALARM_PERIOD, alarm);
        write_reg(CFG_DISCO_PERIOD, disco);
        write_reg(CFG_FAILURE_PERIOD, failure);
    endtask

    // Mostly in range, now and then any 4-bit value
    function automatic logic [DIGIT_W-1:0] flicker_digit();
        if ($urandom_range(0, 4) == 0)
            return DIGIT_W'($urandom);
        return DIGIT_W'($urandom_range(DIGIT_MIN, DIGIT_MAX));
    endfunction

    // Mode change followed by a run of ticks, with a few colour changes and noise
    task automatic random_phase(input int n_items);
        int sent;
        int run_len;
        logic [SET_W-1:0] next_mode;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0)
                next_mode = ($urandom_range(0, 1) == 0) ? MODE_UNDEF_LO : MODE_UNDEF_HI;
            else
                next_mode = SET_W'($urandom_range(MODE_OFF, MODE_FAILURE));
            send_item(CMD_SET_MODE, next_mode, DIGIT_W'($urandom));
            sent++;
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 250)
                                                  : $urandom_range(1, 40);
            repeat (run_len) begin
                case ($urandom_range(0, 19))
                    0:       send_item(CMD_SET_COLOUR, SET_W'($urandom), DIGIT_W'($urandom));
                    1:       send_item(CMD_UNUSED, SET_W'($urandom), DIGIT_W'($urandom));
                    default: send_item(CMD_TICK, SET_W'($urandom), flicker_digit());
                endcase
                sent++;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset periods: unknown command, ignored mode, steady colour
        send_item(CMD_UNUSED, MODE_UNDEF_HI, 4'd15);
        send_item(CMD_SET_MODE, MODE_UNDEF_HI, 4'd0);
        send_item(CMD_SET_COLOUR, COLOUR_YELLOW, 4'd5);
        send_item(CMD_SET_MODE, MODE_ON, 4'd10);
        send_item(CMD_TICK, COLOUR_BLACK, 4'd15);

        // Shortest periods: every effect steps on each tick
        set_periods(10'd1, 10'd1, 10'd1);
        send_item(CMD_SET_MODE, MODE_ALARM, 4'd1);
        send_item(CMD_TICK, COLOUR_BLACK, 4'd1);
        send_item(CMD_TICK, COLOUR_BLACK, 4'd1);
        send_item(CMD_SET_MODE, MODE_DISCO, 4'd1);
        send_item(CMD_TICK, COLOUR_BLACK, 4'd1);
        send_item(CMD_TICK, COLOUR_BLACK, 4'd1);
        // failure runs its six colours, then falls back to off
        send_item(CMD_SET_MODE, MODE_FAILURE, 4'd1);
        repeat (8) send_item(CMD_TICK, COLOUR_BLACK, 4'd1);
        // flicker with out-of-range digits
        send_item(CMD_SET_MODE, MODE_FLICKER, 4'd9);
        send_item(CMD_TICK, COLOUR_BLACK, 4'd0);
        send_item(CMD_SET_MODE, MODE_UNDEF_LO, 4'd15);
        send_item(CMD_TICK, COLOUR_CYAN, 4'd15);
        send_item(CMD_UNUSED, COLOUR_CYAN, 4'd15);

        random_phase(PHASE_ITEMS);

        // Small random periods; receiver holds off so the input side backs up
        set_periods(MS_W'($urandom_range(1, 20)), MS_W'($urandom_range(1, 20)),
                    MS_W'($urandom_range(1, 20)));
        hold_off_req = 1'b1;
        random_phase(PHASE_ITEMS);

        // Longest periods, plus a write to the unused register index
        set_periods(10'd1023, 10'd1023, 10'd1023);
        write_reg(CFG_UNUSED, 10'd5);
        random_phase(PHASE_ITEMS);

        // Zero period behaves as one
        set_periods(10'd0, 10'd1023, 10'd2);
        random_phase(PHASE_ITEMS);

        set_periods(MS_W'($urandom_range(2, 60)), MS_W'($urandom_range(2, 60)),
                    MS_W'($urandom_range(2, 60)));
        random_phase(PHASE_ITEMS);

        set_periods(ALARM_PERIOD_RST, DISCO_PERIOD_RST, FAILURE_PERIOD_RST);
        random_phase(PHASE_ITEMS);

        settle();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
